/* src/assert_macros.svh */
// Assertion helpers included by token_lexer_stream
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) else $error("next-cycle check failed");
`endif

/* src/tls_pkg.sv */
// ----------------------------------------------------------------------------
// tls_pkg
// Types and constants for the streaming lexer.
// ----------------------------------------------------------------------------
`default_nettype none
package tls_pkg;
  localparam int unsigned KindW = 6;
  localparam int unsigned PosW = 16;
  localparam int unsigned LenW = 8;
  localparam logic [KindW-1:0] KIND_KEYWORD0 = 6'd34;
  localparam logic [KindW-1:0] KIND_IDENT = 6'd52;
  localparam logic [KindW-1:0] KIND_INTEGER = 6'd53;
  localparam logic [KindW-1:0] KIND_END = 6'd54;
  localparam logic [KindW-1:0] KIND_BADNUM = 6'd55;
  localparam logic [KindW-1:0] KIND_UNKNOWN = 6'd56;
  localparam logic [KindW-1:0] KIND_NONE = 6'd63;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0, MODE_WORD = 3'd1, MODE_NUM = 3'd2,
    MODE_BADLETTER = 3'd3, MODE_BADDIGITS = 3'd4, MODE_COMMENT = 3'd5
  } mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  column;
    logic [LenW-1:0]  length;
    logic             run_end;
  } token_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       final_char;
  } char_t;

  function automatic logic [KindW-1:0] single_kind(input logic [7:0] c);
    case (c)
      "+": return 6'd0;  "-": return 6'd3;  "*": return 6'd6;
      "/": return 6'd8;  "%": return 6'd10; "=": return 6'd11;
      "<": return 6'd13; ">": return 6'd15; "!": return 6'd17;
      "|": return 6'd19; "&": return 6'd21; ";": return 6'd23;
      ":": return 6'd24; ",": return 6'd25; ".": return 6'd26;
      "#": return 6'd27; "(": return 6'd28; ")": return 6'd29;
      "[": return 6'd30; "]": return 6'd31; "{": return 6'd32;
      "}": return 6'd33;
      default: return KIND_NONE;
    endcase
  endfunction

  function automatic logic can_pair(input logic [7:0] c);
    return c inside {"+", "-", "*", "/", "=", "<", ">", "!", "|", "&"};
  endfunction

  function automatic logic [KindW-1:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
    if (h == "+" && c == "+") return 6'd1;
    if (h == "+" && c == "=") return 6'd2;
    if (h == "-" && c == "-") return 6'd4;
    if (h == "-" && c == "=") return 6'd5;
    if (h == "*" && c == "=") return 6'd7;
    if (h == "/" && c == "=") return 6'd9;
    if (h == "=" && c == "=") return 6'd12;
    if (h == "<" && c == "=") return 6'd14;
    if (h == ">" && c == "=") return 6'd16;
    if (h == "!" && c == "=") return 6'd18;
    if (h == "|" && c == "|") return 6'd20;
    if (h == "&" && c == "&") return 6'd22;
    return KIND_NONE;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // keyword match on the first eight characters; longer words are identifiers
  function automatic logic [KindW-1:0] keyword_kind(input logic [63:0] p,
                                                    input logic [15:0] n);
    logic [63:0] w;
    logic [KindW-1:0] k;
    w = p;
    k = KIND_IDENT;
    case (n)
      16'd2: if (w[15:0] == "fi") k = 6'd38;
      16'd3: begin
        if (w[23:0] == "tni") k = 6'd34;
        else if (w[23:0] == "rof") k = 6'd40;
      end
      16'd4: begin
        if (w[31:0] == "rahc") k = 6'd35;
        else if (w[31:0] == "esle") k = 6'd39;
        else if (w[31:0] == "epyt") k = 6'd46;
        else if (w[31:0] == "diov") k = 6'd47;
        else if (w[31:0] == "eurt") k = 6'd50;
      end
      16'd5: begin
        if (w[39:0] == "taolf") k = 6'd37;
        else if (w[39:0] == "elihw") k = 6'd41;
        else if (w[39:0] == "noinu") k = 6'd44;
        else if (w[39:0] == "ssalc") k = 6'd45;
        else if (w[39:0] == "kaerb") k = 6'd48;
        else if (w[39:0] == "eslaf") k = 6'd51;
      end
      16'd6: begin
        if (w[47:0] == "gnirts") k = 6'd36;
        else if (w[47:0] == "nruter") k = 6'd42;
        else if (w[47:0] == "tcurts") k = 6'd43;
      end
      16'd8: if (w == "eunitnoc") k = 6'd49;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction
endpackage
`default_nettype wire

/* src/tls_char_if.sv */
// ----------------------------------------------------------------------------
// tls_char_if
// Valid/ready channels for characters and tokens.
// ----------------------------------------------------------------------------
`default_nettype none
interface tls_char_if;
  logic valid;
  logic ready;
  tls_pkg::char_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tls_token_if;
  logic valid;
  logic ready;
  tls_pkg::token_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/tls_core.sv */
// ----------------------------------------------------------------------------
// tls_core
// Lexer state and per-character decision; produces up to three tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module tls_core #(
  parameter int unsigned LengthLimit = 255
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire tls_pkg::char_t       char_i,
  input  wire logic [4:0]           tab_width_i,
  output tls_pkg::token_t [2:0]     tok_o,
  output logic [1:0]                cnt_o
);
  localparam int unsigned CntW = $clog2(LengthLimit + 1);

  logic [7:0] held_q, held_d;
  logic hv_q, hv_d;
  tls_pkg::mode_e mode_q, mode_d;
  logic [CntW-1:0] wc_q, wc_d;
  logic [63:0] pre_q, pre_d;
  logic [15:0] line_q, line_d, col_q, col_d, sc_q, sc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0; hv_q <= 1'b0; mode_q <= tls_pkg::MODE_IDLE; wc_q <= '0;
      pre_q <= '0; line_q <= 16'd1; col_q <= 16'd1; sc_q <= 16'd1;
    end else if (step_i) begin
      held_q <= held_d; hv_q <= hv_d; mode_q <= mode_d; wc_q <= wc_d;
      pre_q <= pre_d; line_q <= line_d; col_q <= col_d; sc_q <= sc_d;
    end
  end

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [4:0] n);
    logic [16:0] v;
    v = {1'b0, a} + 17'(n);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [7:0] len8(input logic [CntW-1:0] n);
    return (32'(n) > 255) ? 8'd255 : 8'(n);
  endfunction

  always_comb begin
    logic [7:0] c;
    logic fin, done;
    logic [1:0] n;
    logic [tls_pkg::KindW-1:0] p, wk;
    c = char_i.char_code;
    fin = char_i.final_char;
    held_d = held_q; hv_d = hv_q; mode_d = mode_q; wc_d = wc_q; pre_d = pre_q;
    line_d = line_q; col_d = col_q; sc_d = sc_q;
    done = 1'b0; n = 2'd0;
    tok_o = '0;
    wk = tls_pkg::keyword_kind(pre_q, 16'(wc_q));
    p = tls_pkg::pair_kind(held_q, c);
    if (hv_q) begin
      hv_d = 1'b0;
      if (held_q == "/" && c == "/") begin
        mode_d = tls_pkg::MODE_COMMENT; done = 1'b1;
      end else if (p != tls_pkg::KIND_NONE) begin
        tok_o[n] = '{p, line_d, sc_q, 8'd2, 1'b0}; n = n + 2'd1;
        col_d = sat_add(col_d, 5'd2); done = 1'b1;
      end else begin
        tok_o[n] = '{tls_pkg::single_kind(held_q), line_d, sc_q, 8'd1, 1'b0};
        n = n + 2'd1; col_d = sat_add(col_d, 5'd1);
      end
    end else if (mode_q == tls_pkg::MODE_COMMENT) begin
      if (c == "\n") mode_d = tls_pkg::MODE_IDLE;
      else done = 1'b1;
    end else if (mode_q != tls_pkg::MODE_IDLE) begin
      if ((mode_q == tls_pkg::MODE_WORD && tls_pkg::is_letter(c)) ||
          (mode_q == tls_pkg::MODE_NUM && tls_pkg::is_digit(c)) ||
          ((mode_q == tls_pkg::MODE_BADLETTER || mode_q == tls_pkg::MODE_BADDIGITS) &&
           tls_pkg::is_digit(c)) ||
          (mode_q == tls_pkg::MODE_NUM && tls_pkg::is_letter(c))) begin
        if (mode_q == tls_pkg::MODE_NUM && tls_pkg::is_letter(c))
          mode_d = tls_pkg::MODE_BADLETTER;
        else if (mode_q == tls_pkg::MODE_BADLETTER)
          mode_d = tls_pkg::MODE_BADDIGITS;
        if (32'(wc_q) < 8) pre_d[8*wc_q[2:0] +: 8] = c;
        if (32'(wc_q) < LengthLimit) wc_d = wc_q + 1'b1;
        col_d = sat_add(col_d, 5'd1); done = 1'b1;
      end else begin
        tok_o[n] = '{(mode_q == tls_pkg::MODE_WORD) ? wk :
                     (mode_q == tls_pkg::MODE_NUM) ? tls_pkg::KIND_INTEGER :
                     tls_pkg::KIND_BADNUM, line_d, sc_q, len8(wc_q), 1'b0};
        n = n + 2'd1; mode_d = tls_pkg::MODE_IDLE; wc_d = '0;
      end
    end
    if (!done) begin
      if (tls_pkg::can_pair(c)) begin
        held_d = c; hv_d = 1'b1; sc_d = col_d;
      end else if (tls_pkg::single_kind(c) != tls_pkg::KIND_NONE) begin
        tok_o[n] = '{tls_pkg::single_kind(c), line_d, col_d, 8'd1, 1'b0};
        n = n + 2'd1; col_d = sat_add(col_d, 5'd1);
      end else if (tls_pkg::is_letter(c) || tls_pkg::is_digit(c)) begin
        mode_d = tls_pkg::is_letter(c) ? tls_pkg::MODE_WORD : tls_pkg::MODE_NUM;
        sc_d = col_d; pre_d[7:0] = c; wc_d = CntW'(1);
        col_d = sat_add(col_d, 5'd1);
      end else if (c == " ") begin
        col_d = sat_add(col_d, 5'd1);
      end else if (c == "\t") begin
        col_d = sat_add(col_d, tab_width_i);
      end else if (c == "\r") begin
        col_d = col_d;
      end else if (c == "\n") begin
        if (line_d != 16'hFFFF) line_d = line_d + 16'd1;
        col_d = 16'd1;
      end else begin
        tok_o[n] = '{tls_pkg::KIND_UNKNOWN, line_d, col_d, 8'd1, 1'b0};
        n = n + 2'd1; col_d = sat_add(col_d, 5'd1);
      end
    end
    if (fin) begin
      if (hv_d) begin
        tok_o[n] = '{tls_pkg::single_kind(held_d), line_d, sc_d, 8'd1, 1'b0};
        n = n + 2'd1; col_d = sat_add(col_d, 5'd1);
      end else if (mode_d == tls_pkg::MODE_WORD || mode_d == tls_pkg::MODE_NUM ||
                   mode_d == tls_pkg::MODE_BADLETTER ||
                   mode_d == tls_pkg::MODE_BADDIGITS) begin
        tok_o[n] = '{(mode_d == tls_pkg::MODE_WORD) ?
                     tls_pkg::keyword_kind(pre_d, 16'(wc_d)) :
                     (mode_d == tls_pkg::MODE_NUM) ? tls_pkg::KIND_INTEGER :
                     tls_pkg::KIND_BADNUM, line_d, sc_d, len8(wc_d), 1'b0};
        n = n + 2'd1;
      end
      tok_o[n] = '{tls_pkg::KIND_END, line_d, col_d, 8'd0, 1'b0};
      n = n + 2'd1;
      held_d = '0; hv_d = 1'b0; mode_d = tls_pkg::MODE_IDLE; wc_d = '0; pre_d = '0;
      line_d = 16'd1; col_d = 16'd1; sc_d = 16'd1;
    end
    if (n != 2'd0) tok_o[n - 2'd1].run_end = 1'b1;
    cnt_o = n;
  end
endmodule
`default_nettype wire

/* src/tls_out_queue.sv */
// ----------------------------------------------------------------------------
// tls_out_queue
// Token buffer of up to six entries, drained one token per cycle while out.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module tls_out_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tls_pkg::token_t [2:0] tok_i,
  input  wire logic [1:0]       cnt_i,
  output logic                  space_o,
  tls_token_if.source           out
);
  tls_pkg::token_t [5:0] buf_q, buf_d;
  logic [2:0] fill_q, fill_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fill_q <= '0;
    else fill_q <= fill_d;
  end

  always_ff @(posedge clk_i) buf_q <= buf_d;

  always_comb begin
    logic pop;
    logic [2:0] base;
    pop = out.valid && out.ready;
    buf_d = buf_q;
    if (pop) buf_d = {buf_q[5], buf_q[5:1]};
    base = fill_q - {2'b0, pop};
    if (push_i) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < cnt_i) buf_d[base + 3'(i)] = tok_i[i];
      fill_d = base + {1'b0, cnt_i};
    end else begin
      fill_d = base;
    end
  end

  assign out.valid = fill_q != 3'd0;
  assign out.data = buf_q[0];
  assign space_o = fill_q <= 3'd3;
endmodule
`default_nettype wire

/* src/token_lexer_stream.sv */
// A token is registered in the token queue when its character is accepted.
// Throughput: one character per cycle while the queue has space; a character giving
// several tokens is absorbed at once, the six-entry queue drains one token per cycle when ready.
// Reset: asynchronous, active low; line and column return to 1, tab width 4.
// ----------------------------------------------------------------------------
// token_lexer_stream
// Streaming lexer for C-like text, one character per request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module token_lexer_stream #(
  parameter int unsigned LENGTH_LIMIT = 255
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  tls_char_if.sink        in,
  tls_token_if.source     out
);
  logic [4:0] tab_q;
  logic step, space;
  tls_pkg::token_t [2:0] tok;
  logic [1:0] cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tab_q <= 5'd4;
    else if (cfg_we_i) tab_q <= cfg_wdata_i;
  end

  assign in.ready = space;
  assign step = in.valid && in.ready;

  tls_core #(.LengthLimit(LENGTH_LIMIT)) u_core (
    .clk_i, .rst_ni, .step_i(step), .char_i(in.data), .tab_width_i(tab_q),
    .tok_o(tok), .cnt_o(cnt)
  );

  tls_out_queue u_queue (
    .clk_i, .rst_ni, .push_i(step), .tok_i(tok), .cnt_i(cnt), .space_o(space), .out
  );

  `ASSERT_NEXT(a_final_ends, step && in.data.final_char, out.valid)
  `ASSERT_IMPL(a_line_nonzero, out.valid, out.data.line != 16'd0)
  `ASSERT_IMPL(a_end_len, out.valid && out.data.kind == tls_pkg::KIND_END,
               out.data.length == 8'd0 && out.data.run_end)
endmodule
`default_nettype wire
